### hw/rtl/prrq_pkg.sv
// ----------------------------------------------------------------------------
// prrq_pkg
// Shared sizes, types and codes of the priority round-robin ready queue.
// ----------------------------------------------------------------------------
package prrq_pkg;

    localparam int NUM_LEVELS = 32;
    localparam int NUM_PROCS  = 64;
    localparam int ID_W       = $clog2(NUM_PROCS);
    localparam int LVL_W      = $clog2(NUM_LEVELS);

    typedef logic [ID_W-1:0]       id_t;
    typedef logic [LVL_W-1:0]      lvl_t;
    typedef logic [NUM_LEVELS-1:0] lvl_mask_t;

    // operation codes of an input transfer
    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_NOP      = 2'd3
    } op_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_LINK,
        ST_ADD_W1,
        ST_ADD_W2,
        ST_ADD_EMPTY,
        ST_RM_RD,
        ST_RM_W,
        ST_DSP_RD,
        ST_DSP_SEL,
        ST_DONE
    } state_t;

endpackage

### hw/rtl/priority_round_robin_ready_queue.sv
// ----------------------------------------------------------------------------
// priority_round_robin_ready_queue
// Ready queue with one circular doubly linked list per priority level, kept
// in synchronous link memories, and a nonempty bitmap in flip-flops.
// ----------------------------------------------------------------------------
// States: add to an empty level ST_ADD_EMPTY; add to a nonempty level ST_ADD_RD,
// ST_ADD_LINK, ST_ADD_W1, ST_ADD_W2; remove ST_RM_RD, ST_RM_W; dispatch ST_DSP_RD,
// ST_DSP_SEL (skipped if no level is ready); no operation none; all end in ST_DONE.
// One operation at a time; the head -> tail read chain of an add is longest.
// A waiting result does not block the next input transfer.
// Reset clears the bitmap and control state; link memories are not cleared.
module priority_round_robin_ready_queue
    import prrq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_operation,
    input  logic [ID_W-1:0]  s_proc_id,
    input  logic [LVL_W-1:0] s_proc_priority,
    input  logic [ID_W-1:0]  s_active_id,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [ID_W-1:0]  m_chosen_id,
    output logic             m_any_ready
);

    // link memories
    id_t  head_mem [NUM_LEVELS];
    id_t  succ_mem [NUM_PROCS];
    id_t  pred_mem [NUM_PROCS];
    lvl_t lvl_mem  [NUM_PROCS];

    // registered read data
    id_t  head_rd_reg;
    id_t  succ_rd_reg;
    id_t  pred_rd_reg;
    lvl_t lvl_rd_reg;

    // memory port controls
    logic head_re, head_we, succ_re, succ_we, pred_re, pred_we, lvl_re, lvl_we;
    lvl_t head_raddr, head_waddr;
    id_t  head_wdata;
    id_t  succ_raddr, succ_waddr, succ_wdata;
    id_t  pred_raddr, pred_waddr, pred_wdata;
    id_t  lvl_raddr, lvl_waddr;
    lvl_t lvl_wdata;

    state_t    state_reg, state_next;
    lvl_mask_t nonempty_reg, nonempty_next;
    id_t       pid_reg;
    lvl_t      prio_reg;
    id_t       act_reg;
    lvl_t      top_reg;
    id_t       chosen_reg, chosen_next;
    lvl_t      top_lvl;
    logic      m_valid_reg;
    id_t       m_chosen_id_reg;
    logic      m_any_ready_reg;
    logic      in_xfer;
    logic      out_free;
    logic      rm_solo;

    assign s_ready     = (state_reg == ST_IDLE);
    assign in_xfer     = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign m_valid     = m_valid_reg;
    assign m_chosen_id = m_chosen_id_reg;
    assign m_any_ready = m_any_ready_reg;

    // the removed process is alone in its level
    assign rm_solo = (succ_rd_reg == pid_reg);

    // highest nonempty level
    always_comb begin
        top_lvl = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (nonempty_reg[i]) begin
                top_lvl = LVL_W'(i);
            end
        end
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            nonempty_reg <= '0;
        end else begin
            state_reg    <= state_next;
            nonempty_reg <= nonempty_next;
        end
    end

    // latch the operation on an input transfer
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            pid_reg  <= s_proc_id;
            prio_reg <= s_proc_priority;
            act_reg  <= s_active_id;
            top_reg  <= top_lvl;
        end
        chosen_reg <= chosen_next;
    end

    // next state, memory ports and bitmap update
    always_comb begin
        state_next    = state_reg;
        nonempty_next = nonempty_reg;
        chosen_next   = chosen_reg;
        head_re = 1'b0; head_we = 1'b0; succ_re = 1'b0; succ_we = 1'b0;
        pred_re = 1'b0; pred_we = 1'b0; lvl_re  = 1'b0; lvl_we  = 1'b0;
        head_raddr = top_reg; head_waddr = prio_reg; head_wdata = pid_reg;
        succ_raddr = pid_reg; succ_waddr = pid_reg;  succ_wdata = pid_reg;
        pred_raddr = pid_reg; pred_waddr = pid_reg;  pred_wdata = pid_reg;
        lvl_raddr  = pid_reg; lvl_waddr  = pid_reg;  lvl_wdata  = prio_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    chosen_next = '0;
                    unique case (op_t'(s_operation))
                        OP_ADD: begin
                            state_next = nonempty_reg[s_proc_priority] ?
                                         ST_ADD_RD : ST_ADD_EMPTY;
                        end
                        OP_REMOVE:   state_next = ST_RM_RD;
                        OP_DISPATCH: state_next = (|nonempty_reg) ? ST_DSP_RD : ST_DONE;
                        OP_NOP:      state_next = ST_DONE;
                    endcase
                end
            end
            // first process of a level points at itself
            ST_ADD_EMPTY: begin
                head_we = 1'b1;
                succ_we = 1'b1;
                pred_we = 1'b1;
                lvl_we  = 1'b1;
                nonempty_next[prio_reg] = 1'b1;
                state_next = ST_DONE;
            end
            ST_ADD_RD: begin
                head_re    = 1'b1;
                head_raddr = prio_reg;
                state_next = ST_ADD_LINK;
            end
            // fetch the tail, the head's predecessor
            ST_ADD_LINK: begin
                pred_re    = 1'b1;
                pred_raddr = head_rd_reg;
                state_next = ST_ADD_W1;
            end
            // new process links to head and tail
            ST_ADD_W1: begin
                succ_we    = 1'b1;
                succ_wdata = head_rd_reg;
                pred_we    = 1'b1;
                pred_wdata = pred_rd_reg;
                lvl_we     = 1'b1;
                state_next = ST_ADD_W2;
            end
            // tail and head link back to the new process
            ST_ADD_W2: begin
                succ_we    = 1'b1;
                succ_waddr = pred_rd_reg;
                pred_we    = 1'b1;
                pred_waddr = head_rd_reg;
                state_next = ST_DONE;
            end
            ST_RM_RD: begin
                succ_re    = 1'b1;
                pred_re    = 1'b1;
                lvl_re     = 1'b1;
                state_next = ST_RM_W;
            end
            // unlink and move the head to the successor, or clear the level if alone
            ST_RM_W: begin
                head_we    = 1'b1;
                head_waddr = lvl_rd_reg;
                if (rm_solo) begin
                    head_wdata = '0;
                    nonempty_next[lvl_rd_reg] = 1'b0;
                end else begin
                    head_wdata = succ_rd_reg;
                    pred_we    = 1'b1;
                    pred_waddr = succ_rd_reg;
                    pred_wdata = pred_rd_reg;
                    succ_we    = 1'b1;
                    succ_waddr = pred_rd_reg;
                    succ_wdata = succ_rd_reg;
                end
                state_next = ST_DONE;
            end
            ST_DSP_RD: begin
                head_re    = 1'b1;
                head_raddr = top_reg;
                succ_re    = 1'b1;
                succ_raddr = act_reg;
                lvl_re     = 1'b1;
                lvl_raddr  = act_reg;
                state_next = ST_DSP_SEL;
            end
            // round robin within the active level, else its head
            ST_DSP_SEL: begin
                chosen_next = (lvl_rd_reg == top_reg) ? succ_rd_reg : head_rd_reg;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // level head memory
    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (head_re) begin
            head_rd_reg <= head_mem[head_raddr];
        end
    end

    // successor link memory
    always_ff @(posedge aclk) begin
        if (succ_we) begin
            succ_mem[succ_waddr] <= succ_wdata;
        end
        if (succ_re) begin
            succ_rd_reg <= succ_mem[succ_raddr];
        end
    end

    // predecessor link memory
    always_ff @(posedge aclk) begin
        if (pred_we) begin
            pred_mem[pred_waddr] <= pred_wdata;
        end
        if (pred_re) begin
            pred_rd_reg <= pred_mem[pred_raddr];
        end
    end

    // process level memory
    always_ff @(posedge aclk) begin
        if (lvl_we) begin
            lvl_mem[lvl_waddr] <= lvl_wdata;
        end
        if (lvl_re) begin
            lvl_rd_reg <= lvl_mem[lvl_raddr];
        end
    end

    // result register, freed by an output transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_chosen_id_reg <= chosen_reg;
            m_any_ready_reg <= |nonempty_reg;
        end
    end

    // result shows the bitmap left by the operation
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> (m_any_ready_reg == (|nonempty_reg)))
        else $error("any_ready does not match the level bitmap");

    // dispatch with no ready process yields id zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_operation == OP_DISPATCH && nonempty_reg == '0)
        |=> (state_reg == ST_DONE && chosen_reg == '0))
        else $error("empty dispatch did not return zero");

    // first add to a level marks the level nonempty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADD_EMPTY) |=> nonempty_reg[$past(prio_reg)])
        else $error("add to empty level left bitmap clear");

    // a result is loaded only when the output slot is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && state_reg == ST_DONE) |=> (state_reg == ST_DONE))
        else $error("sequencer left done state while result was stalled");

endmodule
